// File: rtl/ksa_pkg.sv
// Shared types, constants and helper functions for the keyed slot allocator.
// Used by the slot memory, the loss unit and the top level.
package ksa_pkg;

  // Table geometry.
  localparam int SLOT_COUNT = 32;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int LIT_W      = $clog2(SLOT_COUNT + 1);

  // Output field widths.
  localparam int IDX_OUT_W = 5;
  localparam int LIT_OUT_W = 6;

  // Division of a 32-bit product by 1000: multiply by the reciprocal and keep
  // the bits from the shift up. This is exact over the whole 32-bit range.
  localparam int          MAGIC_W    = 29;
  localparam logic [28:0] LOSS_MAGIC = 29'h1062_4DD3;
  localparam int          LOSS_SHIFT = 38;
  localparam int          PROD_W     = 32;
  localparam int          WIDE_W     = PROD_W + MAGIC_W;
  localparam int          LOSS_W     = WIDE_W - LOSS_SHIFT;

  // Operation codes.
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  // How the slot was found.
  typedef enum logic [1:0] {
    HOW_KEY     = 2'd0,
    HOW_EXPIRED = 2'd1,
    HOW_FORCED  = 2'd2,
    HOW_TICK    = 2'd3
  } how_t;

  // One slot entry as held in memory.
  typedef struct packed {
    logic [31:0] owner;
    logic [31:0] expiry;
    logic [15:0] radius;
    logic [15:0] decay;
  } slot_t;

  // Access request from the sequencer to the slot memory.
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
  } mem_req_t;

  // Low bits of a slot index for the result beat.
  function automatic logic [IDX_OUT_W-1:0] idx_out(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W+IDX_OUT_W-1:0] ext;
    ext = (SLOT_W + IDX_OUT_W)'(idx);
    return ext[IDX_OUT_W-1:0];
  endfunction

  // Lit count saturated to the output field.
  function automatic logic [LIT_OUT_W-1:0] lit_out(input logic [LIT_W-1:0] cnt);
    logic [LIT_W+LIT_OUT_W-1:0] ext;
    ext = (LIT_W + LIT_OUT_W)'(cnt);
    if (ext > (LIT_W + LIT_OUT_W)'(63)) begin
      return LIT_OUT_W'(63);
    end
    return ext[LIT_OUT_W-1:0];
  endfunction

endpackage

// File: rtl/ksa_if.sv
// Valid/ready channel interfaces for the keyed slot allocator.
// Depends on nothing but plain logic types.

// Input channel: one item per beat.
interface ksa_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] key;
  logic        [31:0] now_ms;
  logic        [31:0] expiry_ms;
  logic        [15:0] start_radius;
  logic        [15:0] decay_rate;
  logic        [15:0] frame_ms;

  modport source (
    output valid, op, key, now_ms, expiry_ms, start_radius, decay_rate, frame_ms,
    input  ready
  );
  modport sink (
    input  valid, op, key, now_ms, expiry_ms, start_radius, decay_rate, frame_ms,
    output ready
  );
endinterface

// Result channel: one result per beat.
interface ksa_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] slot_index;
  logic [1:0] how_found;
  logic [5:0] lit_count;

  modport source (
    output valid, slot_index, how_found, lit_count,
    input  ready
  );
  modport sink (
    input  valid, slot_index, how_found, lit_count,
    output ready
  );
endinterface

// File: rtl/ksa_slot_mem.sv
// Slot table memory: one read and one write port, registered read.
// Depends on ksa_pkg for the entry type and request struct.
module ksa_slot_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  ksa_pkg::mem_req_t req,
  input  ksa_pkg::slot_t    wr_data,
  output ksa_pkg::slot_t    rd_data
);

  ksa_pkg::slot_t                     mem [ksa_pkg::SLOT_COUNT];
  logic [ksa_pkg::SLOT_COUNT-1:0]     valid_r;
  ksa_pkg::slot_t                     rd_q_r;
  logic                               rd_vld_r;

  // Storage array and registered read.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_q_r <= mem[req.rd_addr];
    end
  end

  // Written flags: an entry never written reads as all zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= valid_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// File: rtl/ksa_loss.sv
// Two-stage radius loss unit: frame_ms * decay, then division by 1000.
// Depends on ksa_pkg for the reciprocal constant and widths.
module ksa_loss (
  input  logic                        clk,
  input  logic [15:0]                 frame_ms,
  input  logic [15:0]                 decay,
  output logic [ksa_pkg::LOSS_W-1:0]  loss
);

  logic [ksa_pkg::PROD_W-1:0] prod_r;
  logic [ksa_pkg::WIDE_W-1:0] wide;
  logic [ksa_pkg::LOSS_W-1:0] loss_r;

  // Reciprocal multiply of the registered product.
  assign wide = ksa_pkg::WIDE_W'(prod_r) * ksa_pkg::WIDE_W'(ksa_pkg::LOSS_MAGIC);

  // Stage one holds the product, stage two the quotient.
  always_ff @(posedge clk) begin
    prod_r <= ksa_pkg::PROD_W'(frame_ms) * ksa_pkg::PROD_W'(decay);
    loss_r <= wide[ksa_pkg::WIDE_W-1:ksa_pkg::LOSS_SHIFT];
  end

  assign loss = loss_r;

endmodule

// File: rtl/keyed_slot_allocator_with_expiry.sv
// Keyed slot allocator with expiry: sequencer, walk pipeline and result register.
// Depends on ksa_pkg, ksa_if, ksa_slot_mem and ksa_loss.
//
// Usage: items arrive on in_ch (valid/ready); an item is taken when both are
// high. Op allocate picks a slot (first owner match on a nonzero key, else the
// first slot whose expiry lies before now_ms, else slot 0) and loads it. Op
// tick ages every lit slot: expired ones go dark, the others lose
// frame_ms * decay / 1000 of radius, floored at zero.
// Each item yields one result beat on out_ch with the slot index, how it was
// found and the number of lit slots after the item.
// Timing: one slot is read per cycle through the single read port. An item
// passes through capture, SLOT_COUNT reads, the drain of the read and loss
// pipeline, a check that the pipeline is empty, and then the allocate write
// and the load of the result register, which waits until the held result
// has gone. One item is in work at a time; the next one can be taken in the
// cycle after the previous result is loaded.
// Reset clears the control state and marks every slot as unwritten, so the
// table reads as all zero at once. When the receiver stalls, the result stays
// in the output register; the next item is still taken and walked, and its
// result waits until the held beat has gone.
module keyed_slot_allocator_with_expiry (
  input  logic          clk,
  input  logic          rst_n,
  ksa_in_if.sink        in_ch,
  ksa_out_if.source     out_ch
);

  localparam int SW = ksa_pkg::SLOT_W;
  localparam int LW = ksa_pkg::LIT_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Captured item.
  logic               op_r;
  logic        [31:0] key_r;
  logic        [31:0] now_r;
  logic        [31:0] exp_r;
  logic        [15:0] rad_r;
  logic        [15:0] dec_r;
  logic        [15:0] frame_r;

  // Walk pipeline.
  logic [SW:0]        cnt_r;
  logic               s1_v_r, s2_v_r, s3_v_r;
  logic [SW-1:0]      s1_idx_r, s2_idx_r, s3_idx_r;
  ksa_pkg::slot_t     s2_e_r, s3_e_r;
  logic               s2_dark_r, s3_dark_r;

  // Allocate search results.
  logic               match_f_r, expf_r;
  logic [SW-1:0]      match_idx_r, exp_idx_r;
  logic [15:0]        match_rad_r, exp_rad_r, rad0_r;

  // Lit counts.
  logic [LW-1:0]      tick_cnt_r;
  logic [LW-1:0]      lit_cnt_r, lit_cnt_nxt;

  // Result register.
  logic               out_valid_r;
  logic [4:0]         out_idx_r;
  logic [1:0]         out_how_r;
  logic [5:0]         out_lit_r;

  ksa_pkg::mem_req_t  req;
  ksa_pkg::slot_t     rd_data;
  ksa_pkg::slot_t     wr_data;
  logic [ksa_pkg::LOSS_W-1:0] loss;

  logic               issue;
  logic               walk_done;
  logic               out_free;
  logic               is_tick;
  logic [15:0]        new_rad;
  logic               s3_wr;
  logic [SW-1:0]      pick_idx;
  logic [1:0]         pick_how;
  logic [15:0]        pick_old;
  ksa_pkg::slot_t     alloc_e;

  ksa_slot_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  ksa_loss u_loss (
    .clk      (clk),
    .frame_ms (frame_r),
    .decay    (rd_data.decay),
    .loss     (loss)
  );

  assign is_tick   = (op_r == ksa_pkg::OP_TICK);
  assign issue     = (state_r == ST_WALK) && (cnt_r != (SW+1)'(ksa_pkg::SLOT_COUNT));
  assign walk_done = (state_r == ST_WALK) && !issue && !s1_v_r && !s2_v_r && !s3_v_r;
  assign out_free  = !out_valid_r || out_ch.ready;

  // Aged radius at the last pipeline stage.
  always_comb begin
    if (s3_dark_r || (s3_e_r.radius == '0)) begin
      new_rad = '0;
    end else if (loss >= ksa_pkg::LOSS_W'(s3_e_r.radius)) begin
      new_rad = '0;
    end else begin
      new_rad = s3_e_r.radius - loss[15:0];
    end
  end

  assign s3_wr = s3_v_r && is_tick && (s3_e_r.radius != '0);

  // Slot choice for allocate.
  always_comb begin
    if (match_f_r) begin
      pick_idx = match_idx_r;
      pick_how = ksa_pkg::HOW_KEY;
      pick_old = match_rad_r;
    end else if (expf_r) begin
      pick_idx = exp_idx_r;
      pick_how = ksa_pkg::HOW_EXPIRED;
      pick_old = exp_rad_r;
    end else begin
      pick_idx = '0;
      pick_how = ksa_pkg::HOW_FORCED;
      pick_old = rad0_r;
    end
  end

  always_comb begin
    alloc_e.owner  = key_r;
    alloc_e.expiry = exp_r;
    alloc_e.radius = rad_r;
    alloc_e.decay  = dec_r;
  end

  // Memory requests: walk reads, aged write-back, allocate load.
  always_comb begin
    req.rd_en   = issue;
    req.rd_addr = cnt_r[SW-1:0];
    req.wr_en   = 1'b0;
    req.wr_addr = s3_idx_r;
    wr_data     = s3_e_r;
    if (s3_wr) begin
      req.wr_en     = 1'b1;
      wr_data.radius = new_rad;
    end else if ((state_r == ST_FIN) && out_free && !is_tick) begin
      req.wr_en   = 1'b1;
      req.wr_addr = pick_idx;
      wr_data     = alloc_e;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // New lit count after the item.
  always_comb begin
    if (is_tick) begin
      lit_cnt_nxt = tick_cnt_r;
    end else begin
      lit_cnt_nxt = lit_cnt_r - LW'(pick_old != '0) + LW'(rad_r != '0);
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      lit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= issue;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      if ((state_r == ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
        lit_cnt_r   <= lit_cnt_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item capture, walk counter and search state.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r        <= in_ch.op;
      key_r       <= in_ch.key;
      now_r       <= in_ch.now_ms;
      exp_r       <= in_ch.expiry_ms;
      rad_r       <= in_ch.start_radius;
      dec_r       <= in_ch.decay_rate;
      frame_r     <= in_ch.frame_ms;
      cnt_r       <= '0;
      match_f_r   <= 1'b0;
      expf_r      <= 1'b0;
      tick_cnt_r  <= '0;
    end else begin
      if (issue) begin
        cnt_r <= cnt_r + (SW+1)'(1);
      end
      // Search for the first owner match and the first expired slot.
      if (s1_v_r && !is_tick) begin
        if ((key_r != '0) && !match_f_r && (rd_data.owner == key_r)) begin
          match_f_r   <= 1'b1;
          match_idx_r <= s1_idx_r;
          match_rad_r <= rd_data.radius;
        end
        if (!expf_r && (rd_data.expiry < now_r)) begin
          expf_r    <= 1'b1;
          exp_idx_r <= s1_idx_r;
          exp_rad_r <= rd_data.radius;
        end
      end
      // Count slots still lit after aging.
      if (s3_v_r && is_tick && (new_rad != '0)) begin
        tick_cnt_r <= tick_cnt_r + LW'(1);
      end
    end
    if (s1_v_r && (s1_idx_r == '0)) begin
      rad0_r <= rd_data.radius;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    s1_idx_r  <= cnt_r[SW-1:0];
    s2_idx_r  <= s1_idx_r;
    s3_idx_r  <= s2_idx_r;
    s2_e_r    <= rd_data;
    s3_e_r    <= s2_e_r;
    s2_dark_r <= (rd_data.expiry < now_r);
    s3_dark_r <= s2_dark_r;
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if ((state_r == ST_FIN) && out_free) begin
      out_idx_r <= is_tick ? '0 : ksa_pkg::idx_out(pick_idx);
      out_how_r <= is_tick ? ksa_pkg::HOW_TICK : pick_how;
      out_lit_r <= ksa_pkg::lit_out(lit_cnt_nxt);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.slot_index = out_idx_r;
  assign out_ch.how_found  = out_how_r;
  assign out_ch.lit_count  = out_lit_r;

endmodule
